[rtl/core/gtss_pkg.sv]
package gtss_pkg;

    // Q3.13 angle
    typedef logic signed [15:0] t_angle;

    // Input item
    typedef struct packed {
        logic [1:0]         req_type;
        logic               target_seen;
        logic [15:0]        target_age;
        logic signed [23:0] target_x;
        logic signed [23:0] target_y;
        logic signed [23:0] target_z;
        logic [3:0]         entry_index;
        t_angle             entry_yaw;
        t_angle             entry_pitch;
    } t_in_item;

    // Result item
    typedef struct packed {
        t_angle aim_yaw;
        t_angle aim_pitch;
        logic   smooth_move;
    } t_out_item;

    // One scan table row
    typedef struct packed {
        t_angle yaw;
        t_angle pitch;
    } t_scan_entry;

    // Request codes
    localparam logic [1:0] REQ_TICK        = 2'd0;
    localparam logic [1:0] REQ_GETUP_START = 2'd1;
    localparam logic [1:0] REQ_GETUP_END   = 2'd2;
    localparam logic [1:0] REQ_WRITE_ENTRY = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SEEN_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_DWELL        = 2'd1;
    localparam logic [1:0] CFG_PITCH_BIAS   = 2'd2;
    localparam logic [1:0] CFG_SCAN_COUNT   = 2'd3;

    // CORDIC datapath widths
    localparam int XY_W   = 27;   // 24-bit input, sign flip, gain and sqrt(2) growth
    localparam int Z_W    = 35;   // angle accumulator, 2^-30 rad units
    localparam int ANG_W  = 18;   // accumulator rounded to Q5.13
    localparam int MAX_STEPS = 24;

    localparam logic signed [Z_W-1:0] PI_UNITS = 35'sd3373259426;

    typedef enum logic [2:0] {
        S_IDLE,
        S_YAW,
        S_PITCH,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic signed [23:0] x;
        logic signed [23:0] y;
    } t_cordic_req;

    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic signed [ANG_W-1:0] angle;
    } t_cordic_rsp;

    // atan(2^-i) in 2^-30 rad units
    function automatic logic [30:0] f_atan(input logic [4:0] i);
        logic [30:0] v;
        case (i)
            5'd0:  v = 31'd843314857;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043837;
            5'd3:  v = 31'd133525159;
            5'd4:  v = 31'd67021687;
            5'd5:  v = 31'd33543516;
            5'd6:  v = 31'd16775851;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194283;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048576;
            5'd11: v = 31'd524288;
            5'd12: v = 31'd262144;
            5'd13: v = 31'd131072;
            5'd14: v = 31'd65536;
            5'd15: v = 31'd32768;
            5'd16: v = 31'd16384;
            5'd17: v = 31'd8192;
            5'd18: v = 31'd4096;
            5'd19: v = 31'd2048;
            5'd20: v = 31'd1024;
            5'd21: v = 31'd512;
            5'd22: v = 31'd256;
            5'd23: v = 31'd128;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/gaze_track_or_scan_sequencer.sv]
// Head aiming sequencer. Items arrive on a valid/ready channel: ticks, getup
// start/end (set/clear a hold that suppresses results), and scan table writes.
// An unheld tick with a fresh target (target_seen and target_age below the
// timeout) yields one smoothed item with yaw = atan2(y,x) and a saturated
// pitch = atan2(z,x) + pitch_bias; otherwise, once more than dwell_ticks ticks
// have passed since the last scan move, it yields the next scan table entry
// unsmoothed. Getup, table-write, held and silent ticks leave the block
// ready in S_IDLE; a scan move passes through a registered table read
// (S_READ) and S_EMIT, and a tracked tick through S_YAW and S_PITCH, in
// which one iterative CORDIC vectoring unit runs twice, once per angle,
// and then S_EMIT. A finished result sits in an output register; the
// block goes back to accepting items while it waits, and stalls only if
// a second result is ready before the first was taken. Table entries that
// were never written read back as garbage. Configuration writes take
// effect at once and must only be made while the block is idle.
module gaze_track_or_scan_sequencer
    import gtss_pkg::*;
#(
    parameter int SCAN_DEPTH  = 16,
    parameter int ANGLE_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // pointer width and a count width that can hold SCAN_DEPTH and scan_count
    localparam int PW = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;
    localparam int CW = ($clog2(SCAN_DEPTH + 1) > 5) ? $clog2(SCAN_DEPTH + 1) : 5;

    // configuration
    logic [15:0]        r_seen_timeout;
    logic [15:0]        r_dwell;
    logic signed [15:0] r_pitch_bias;
    logic [4:0]         r_scan_count;

    // control state
    t_state       r_state, n_state;
    logic         r_hold, n_hold;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [15:0]  r_tsm, n_tsm;          // ticks since last scan move
    logic         r_out_valid, n_out_valid;

    // payload
    logic signed [23:0] r_x, n_x;
    logic signed [23:0] r_z, n_z;
    t_angle             r_res_yaw, n_res_yaw;
    t_angle             r_res_pitch, n_res_pitch;
    logic               r_res_smooth, n_res_smooth;
    t_out_item          r_out_item, n_out_item;

    // unit links
    t_cordic_req w_creq;
    t_cordic_rsp w_crsp;
    logic        w_mem_we, w_mem_re;
    logic [PW-1:0] w_waddr;
    t_scan_entry w_wdata, w_rdata;

    // combinational helpers
    logic              w_accept;
    logic              w_track;
    logic [15:0]       w_tsm_inc;
    logic [CW-1:0]     w_cnt_raw, w_cnt, w_ptr_inc;
    logic [PW-1:0]     w_ptr_wr, w_ptr_next;
    logic [PW+3:0]     w_idx_wide;
    logic signed [ANG_W:0] w_pitch_sum;
    t_angle            w_pitch_sat;

    gtss_cordic #(
        .ANGLE_STEPS(ANGLE_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_creq),
        .o_rsp  (w_crsp)
    );

    gtss_scan_table #(
        .DEPTH(SCAN_DEPTH),
        .AW   (PW)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_mem_re),
        .i_raddr(w_ptr_wr),
        .o_rdata(w_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_timeout <= 16'd90;
            r_dwell        <= 16'd45;
            r_pitch_bias   <= '0;
            r_scan_count   <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEEN_TIMEOUT: r_seen_timeout <= i_cfg_data;
                CFG_DWELL:        r_dwell        <= i_cfg_data;
                CFG_PITCH_BIAS:   r_pitch_bias   <= i_cfg_data;
                CFG_SCAN_COUNT:   r_scan_count   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // scan index arithmetic
    always_comb begin
        // count in use: 0 means 1, clamp to table depth
        w_cnt_raw = CW'(r_scan_count);
        if (w_cnt_raw == '0) begin
            w_cnt = CW'(1);
        end else if (w_cnt_raw > CW'(SCAN_DEPTH)) begin
            w_cnt = CW'(SCAN_DEPTH);
        end else begin
            w_cnt = w_cnt_raw;
        end
        // pointer beyond count wraps before use
        w_ptr_wr   = (CW'(r_ptr) >= w_cnt) ? '0 : r_ptr;
        w_ptr_inc  = CW'(w_ptr_wr) + CW'(1);
        w_ptr_next = (w_ptr_inc >= w_cnt) ? '0 : w_ptr_inc[PW-1:0];

        w_tsm_inc  = (r_tsm != 16'hFFFF) ? r_tsm + 16'd1 : r_tsm;
        w_track    = i_in_item.target_seen && (i_in_item.target_age < r_seen_timeout);

        w_idx_wide = {{PW{1'b0}}, i_in_item.entry_index};
        w_waddr    = w_idx_wide[PW-1:0];
        w_wdata.yaw   = i_in_item.entry_yaw;
        w_wdata.pitch = i_in_item.entry_pitch;

        // tracked pitch with bias, saturated to 16 bits
        w_pitch_sum = (ANG_W + 1)'(w_crsp.angle) + (ANG_W + 1)'(r_pitch_bias);
        if (w_pitch_sum > (ANG_W + 1)'(32767)) begin
            w_pitch_sat = 16'sh7FFF;
        end else if (w_pitch_sum < -(ANG_W + 1)'(32768)) begin
            w_pitch_sat = 16'sh8000;
        end else begin
            w_pitch_sat = w_pitch_sum[15:0];
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_hold       = r_hold;
        n_ptr        = r_ptr;
        n_tsm        = r_tsm;
        n_x          = r_x;
        n_z          = r_z;
        n_res_yaw    = r_res_yaw;
        n_res_pitch  = r_res_pitch;
        n_res_smooth = r_res_smooth;
        n_out_item   = r_out_item;
        n_out_valid  = r_out_valid && !i_out_ready;

        w_creq.start = 1'b0;
        w_creq.x     = i_in_item.target_x;
        w_creq.y     = i_in_item.target_y;
        w_mem_we     = 1'b0;
        w_mem_re     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.req_type)
                        REQ_GETUP_START: n_hold = 1'b1;
                        REQ_GETUP_END:   n_hold = 1'b0;
                        REQ_WRITE_ENTRY: begin
                            w_mem_we = (int'(i_in_item.entry_index) < SCAN_DEPTH);
                        end
                        default: begin  // tick
                            n_tsm = w_tsm_inc;
                            if (!r_hold) begin
                                if (w_track) begin
                                    w_creq.start = 1'b1;
                                    n_x          = i_in_item.target_x;
                                    n_z          = i_in_item.target_z;
                                    n_state      = S_YAW;
                                end else if (w_tsm_inc <= r_dwell) begin
                                    n_ptr = w_ptr_wr;
                                end else begin
                                    // scan move: fetch entry, step pointer
                                    n_tsm    = '0;
                                    w_mem_re = 1'b1;
                                    n_ptr    = w_ptr_next;
                                    n_state  = S_READ;
                                end
                            end
                        end
                    endcase
                end
            end
            S_YAW: begin
                if (w_crsp.done) begin
                    n_res_yaw    = w_crsp.angle[15:0];
                    w_creq.start = 1'b1;
                    w_creq.x     = r_x;
                    w_creq.y     = r_z;
                    n_state      = S_PITCH;
                end
            end
            S_PITCH: begin
                if (w_crsp.done) begin
                    n_res_pitch  = w_pitch_sat;
                    n_res_smooth = 1'b1;
                    n_state      = S_EMIT;
                end
            end
            S_READ: begin
                n_res_yaw    = w_rdata.yaw;
                n_res_pitch  = w_rdata.pitch;
                n_res_smooth = 1'b0;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    n_out_item.aim_yaw     = r_res_yaw;
                    n_out_item.aim_pitch   = r_res_pitch;
                    n_out_item.smooth_move = r_res_smooth;
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hold      <= 1'b0;
            r_ptr       <= '0;
            r_tsm       <= 16'hFFFF;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hold      <= n_hold;
            r_ptr       <= n_ptr;
            r_tsm       <= n_tsm;
            r_out_valid <= n_out_valid;
        end
        r_x          <= n_x;
        r_z          <= n_z;
        r_res_yaw    <= n_res_yaw;
        r_res_pitch  <= n_res_pitch;
        r_res_smooth <= n_res_smooth;
        r_out_item   <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // CORDIC only finishes while the sequencer waits on it
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_crsp.done |-> (r_state == S_YAW || r_state == S_PITCH))
        else $error("cordic done outside an angle run");

    // new items only when the shared unit is free
    a_ready_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_crsp.busy)
        else $error("ready while cordic busy");

    // a scan move restarts the dwell count
    a_scan_clears_tsm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_tsm == 16'd0))
        else $error("scan move without dwell reset");

    // pointer stays inside the table
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_ptr) < SCAN_DEPTH)
        else $error("scan pointer out of range");

endmodule

[rtl/core/gtss_cordic.sv]
module gtss_cordic
    import gtss_pkg::*;
#(
    parameter int ANGLE_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);

    localparam int STEPS = (ANGLE_STEPS > MAX_STEPS) ? MAX_STEPS : ANGLE_STEPS;
    localparam logic [4:0] LAST = 5'(STEPS - 1);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic                    r_zero, n_zero;
    logic [4:0]              r_i, n_i;
    logic signed [XY_W-1:0]  r_x, n_x;
    logic signed [XY_W-1:0]  r_y, n_y;
    logic signed [Z_W-1:0]   r_z, n_z;

    logic signed [XY_W-1:0]  w_xin, w_yin, w_xs, w_ys;
    logic signed [Z_W-1:0]   w_atan, w_round;

    always_comb begin
        w_xin   = XY_W'(i_req.x);
        w_yin   = XY_W'(i_req.y);
        w_xs    = r_x >>> r_i;
        w_ys    = r_y >>> r_i;
        w_atan  = Z_W'(f_atan(r_i));
        w_round = r_z + Z_W'(65536);

        n_busy = r_busy;
        n_done = 1'b0;
        n_zero = r_zero;
        n_i    = r_i;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;

        if (i_req.start) begin
            n_i = '0;
            if (w_xin == '0 && w_yin == '0) begin
                // atan2(0,0) is defined as zero
                n_zero = 1'b1;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_zero = 1'b0;
                n_busy = 1'b1;
                if (w_xin[XY_W-1]) begin
                    // left half plane: rotate by pi first
                    n_x = -w_xin;
                    n_y = -w_yin;
                    n_z = w_yin[XY_W-1] ? -PI_UNITS : PI_UNITS;
                end else begin
                    n_x = w_xin;
                    n_y = w_yin;
                    n_z = '0;
                end
            end
        end else if (r_busy) begin
            if (!r_y[XY_W-1]) begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_atan;
            end else begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_atan;
            end
            n_i = r_i + 5'd1;
            if (r_i == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_zero <= 1'b0;
            r_i    <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_zero <= n_zero;
            r_i    <= n_i;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_rsp.busy  = r_busy;
    assign o_rsp.done  = r_done;
    assign o_rsp.angle = r_zero ? '0 : w_round[Z_W-1:Z_W-ANG_W];

endmodule

[rtl/core/gtss_scan_table.sv]
module gtss_scan_table
    import gtss_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_scan_entry   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_scan_entry   o_rdata
);

    t_scan_entry r_mem [DEPTH];
    t_scan_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[tb/gaze_track_or_scan_sequencer_test.sv]
`timescale 1ns / 1ps

module gaze_track_or_scan_sequencer_test;
    import gtss_pkg::*;

    localparam int SLOT_COUNT   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_MAX    = 25736;      // pi in Q3.13
    localparam int SETTLE_CYCLES = 2 * CORDIC_STEPS + 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1830;
    localparam int PHASES       = 8;

    // atan(2^-i) and pi, both in 2^-30 rad
    localparam longint HALF_TURN_RAD = 64'sd3373259426;
    localparam longint ATAN_STEP_RAD [16] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
        524288, 262144, 131072, 65536, 32768};

    // receiver ready patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_EVERY_THIRD,
        STALL_COIN,
        STALL_SPARSE
    } t_stall_pattern;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    t_out_item   o_out_item;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_SEEN_TIMEOUT;
    logic [15:0] i_cfg_data  = '0;

    gaze_track_or_scan_sequencer #(
        .SCAN_DEPTH  (SLOT_COUNT),
        .ANGLE_STEPS (CORDIC_STEPS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Aim predictor: mirror of the sequencer state and its registers
    // ------------------------------------------------------------------
    int unsigned cfg_timeout = 90;
    int unsigned cfg_dwell   = 45;
    int          cfg_bias    = 0;
    int unsigned cfg_count   = 1;

    logic        hold_on    = 1'b0;
    t_angle      slot_yaw   [SLOT_COUNT];
    t_angle      slot_pitch [SLOT_COUNT];
    int unsigned scan_ptr   = 0;
    int unsigned ticks_idle = 16'hFFFF;     // saturated out of reset

    t_out_item   pending_aims [$];          // aims still owed by the block

    int unsigned items_sent    = 0;
    int unsigned tracked_seen  = 0;
    int unsigned scans_seen    = 0;
    int unsigned settings_done = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;

    // CORDIC vectoring atan2, result in Q3.13 with round half up
    function automatic longint atan2_q13(input longint y_in, input longint x_in);
        longint x, y, acc, nx, ny;
        x   = x_in;
        y   = y_in;
        acc = 0;
        if (x == 0 && y == 0)
            return 0;
        // fold the left half plane onto the right one
        if (x < 0) begin
            acc = (y >= 0) ? HALF_TURN_RAD : -HALF_TURN_RAD;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx  = x + (y >>> i);
                ny  = y - (x >>> i);
                acc = acc + ATAN_STEP_RAD[i];
            end else begin
                nx  = x - (y >>> i);
                ny  = y + (x >>> i);
                acc = acc - ATAN_STEP_RAD[i];
            end
            x = nx;
            y = ny;
        end
        return (acc + 65536) >>> 17;
    endfunction

    function automatic void compute_aim(input t_in_item it);
        t_out_item   aim;
        longint      pitch;
        int unsigned span;
        case (it.req_type)
            REQ_GETUP_START: hold_on = 1'b1;
            REQ_GETUP_END:   hold_on = 1'b0;
            REQ_WRITE_ENTRY: begin
                slot_yaw[it.entry_index]   = it.entry_yaw;
                slot_pitch[it.entry_index] = it.entry_pitch;
            end
            default: begin
                // every tick ages the last move, even a held one
                if (ticks_idle < 16'hFFFF)
                    ticks_idle++;
                if (!hold_on) begin
                    if (it.target_seen && it.target_age < cfg_timeout) begin
                        aim.aim_yaw = t_angle'(atan2_q13($signed(it.target_y),
                                                         $signed(it.target_x)));
                        pitch = atan2_q13($signed(it.target_z), $signed(it.target_x))
                                + cfg_bias;
                        if (pitch > 32767)
                            pitch = 32767;
                        if (pitch < -32768)
                            pitch = -32768;
                        aim.aim_pitch   = t_angle'(pitch);
                        aim.smooth_move = 1'b1;
                        pending_aims    = {pending_aims, aim};
                    end else begin
                        // count 0 means 1, anything past the table means all of it
                        span = (cfg_count == 0) ? 1 :
                               (cfg_count > SLOT_COUNT) ? SLOT_COUNT : cfg_count;
                        if (scan_ptr >= span)
                            scan_ptr = 0;
                        if (ticks_idle > cfg_dwell) begin
                            ticks_idle      = 0;
                            aim.aim_yaw     = slot_yaw[scan_ptr];
                            aim.aim_pitch   = slot_pitch[scan_ptr];
                            aim.smooth_move = 1'b0;
                            pending_aims    = {pending_aims, aim};
                            scan_ptr++;
                            if (scan_ptr >= span)
                                scan_ptr = 0;
                        end
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    // Sends one item; bursts of back-to-back items are split by random gaps.
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;                       // no idling at all
                2:       gap = $urandom_range(11, 45);  // may span a whole CORDIC run
                default: gap = $urandom_range(1, 10);
            endcase
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        compute_aim(it);
    endtask

    // Drops valid and lets the block drain before a register write.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_aims.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SEEN_TIMEOUT: cfg_timeout = 32'(value);
            CFG_DWELL:        cfg_dwell   = 32'(value);
            CFG_PITCH_BIAS:   cfg_bias    = 32'($signed(value));
            CFG_SCAN_COUNT:   cfg_count   = 32'(value[4:0]);
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int unsigned timeout, input int unsigned dwell,
                                 input int bias, input int unsigned count);
        wait_idle();
        write_reg(CFG_SEEN_TIMEOUT, timeout[15:0]);
        write_reg(CFG_DWELL, dwell[15:0]);
        write_reg(CFG_PITCH_BIAS, bias[15:0]);
        write_reg(CFG_SCAN_COUNT, count[15:0]);
        settings_done++;
    endtask

    // ------------------------------------------------------------------
    // Item builders; unused fields carry random bits
    // ------------------------------------------------------------------
    function automatic t_in_item noise_item();
        t_in_item it;
        it.req_type    = 2'($urandom_range(0, 3));
        it.target_seen = 1'($urandom_range(0, 1));
        it.target_age  = 16'($urandom());
        it.target_x    = 24'($urandom());
        it.target_y    = 24'($urandom());
        it.target_z    = 24'($urandom());
        it.entry_index = 4'($urandom());
        it.entry_yaw   = 16'($urandom());
        it.entry_pitch = 16'($urandom());
        return it;
    endfunction

    function automatic t_in_item tick_item(input logic seen, input logic [15:0] age,
                                           input logic signed [23:0] x,
                                           input logic signed [23:0] y,
                                           input logic signed [23:0] z);
        t_in_item it;
        it             = noise_item();
        it.req_type    = REQ_TICK;
        it.target_seen = seen;
        it.target_age  = age;
        it.target_x    = x;
        it.target_y    = y;
        it.target_z    = z;
        return it;
    endfunction

    function automatic t_in_item write_item(input logic [3:0] idx, input t_angle yaw,
                                            input t_angle pitch);
        t_in_item it;
        it             = noise_item();
        it.req_type    = REQ_WRITE_ENTRY;
        it.entry_index = idx;
        it.entry_yaw   = yaw;
        it.entry_pitch = pitch;
        return it;
    endfunction

    function automatic t_in_item request_item(input logic [1:0] req);
        t_in_item it;
        it          = noise_item();
        it.req_type = req;
        return it;
    endfunction

    function automatic logic signed [23:0] pick_coord();
        int r;
        r = $urandom();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 24'sh7FFFFF;
            2:       return 24'sh800000;
            3, 4:    return r[23:0];
            5:       return 24'(int'($urandom_range(0, 511)) - 256);
            default: return 24'(r >>> $urandom_range(8, 30));
        endcase
    endfunction

    function automatic t_angle pick_angle();
        case ($urandom_range(0, 5))
            0:       return t_angle'(ANGLE_MAX);
            1:       return t_angle'(-ANGLE_MAX);
            2:       return '0;
            default: return t_angle'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
        endcase
    endfunction

    // age mostly under the timeout, sometimes right at the edge or anywhere
    function automatic logic [15:0] pick_age();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom());
            1:       return 16'(cfg_timeout - 1);
            2:       return 16'(cfg_timeout);
            default: return 16'($urandom_range(0, (cfg_timeout == 0) ? 0 : cfg_timeout - 1));
        endcase
    endfunction

    // a tick that cannot track: no target, or a target too old
    function automatic t_in_item lost_tick();
        if ($urandom_range(0, 1) == 0 || cfg_timeout > 16'hFFFF)
            return tick_item(1'b0, 16'($urandom()), pick_coord(), pick_coord(),
                             pick_coord());
        return tick_item(1'b1, 16'($urandom_range(cfg_timeout, 16'hFFFF)),
                         pick_coord(), pick_coord(), pick_coord());
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready pattern and checking
    // ------------------------------------------------------------------
    t_stall_pattern stall_pattern = STALL_NONE;
    int unsigned    pattern_left  = 0;
    int unsigned    pattern_step  = 0;

    always @(negedge i_clk) begin
        pattern_step <= pattern_step + 1;
        if (pattern_left == 0) begin
            stall_pattern <= t_stall_pattern'($urandom_range(0, 3));
            pattern_left  <= $urandom_range(64, 256);
        end else begin
            pattern_left <= pattern_left - 1;
        end
        case (stall_pattern)
            STALL_NONE:        i_out_ready <= 1'b1;
            STALL_EVERY_THIRD: i_out_ready <= (pattern_step % 3 == 0);
            STALL_COIN:        i_out_ready <= 1'($urandom_range(0, 1));
            default:           i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    t_out_item owed;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_aims.size() == 0) begin
                report_mismatch("unexpected aim, smooth_move",
                                int'(o_out_item.smooth_move), 0);
            end else begin
                owed = pending_aims.pop_front();
                if (o_out_item.aim_yaw !== owed.aim_yaw)
                    report_mismatch("aim_yaw", int'(o_out_item.aim_yaw),
                                    int'(owed.aim_yaw));
                if (o_out_item.aim_pitch !== owed.aim_pitch)
                    report_mismatch("aim_pitch", int'(o_out_item.aim_pitch),
                                    int'(owed.aim_pitch));
                if (o_out_item.smooth_move !== owed.smooth_move)
                    report_mismatch("smooth_move", int'(o_out_item.smooth_move),
                                    int'(owed.smooth_move));
                if (owed.smooth_move)
                    tracked_seen++;
                else
                    scans_seen++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d aims outstanding",
                     cycle_count, pending_aims.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the idle count is saturated, so the first free tick
    // jumps straight to slot 0.
    task automatic test_first_scan();
        send_item(write_item(4'd0, t_angle'(ANGLE_MAX), t_angle'(-ANGLE_MAX)));
        send_item(write_item(4'd1, t_angle'(-ANGLE_MAX), t_angle'(ANGLE_MAX)));
        send_item(write_item(4'd2, '0, '0));
        send_item(tick_item(1'b0, 16'd0, '0, '0, '0));
    endtask

    // Quadrants, axes, the zero vector and the age boundary.
    task automatic test_tracking_angles();
        send_item(tick_item(1'b1, 16'd0, '0, '0, '0));
        send_item(tick_item(1'b1, 16'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000));
        send_item(tick_item(1'b1, 16'd0, 24'sh800000, '0, -24'sd1));
        send_item(tick_item(1'b1, 16'd1, 24'sh800000, 24'sh800000, 24'sh7FFFFF));
        send_item(tick_item(1'b1, 16'd2, '0, 24'sh7FFFFF, 24'sh800000));
        send_item(tick_item(1'b1, 16'd89, 24'sd65536, -24'sd65536, 24'sd3));
        // age equal to the timeout falls back to scanning
        send_item(tick_item(1'b1, 16'd90, 24'sd65536, 24'sd65536, 24'sd65536));
        send_item(tick_item(1'b0, 16'd0, 24'sd65536, 24'sd65536, 24'sd65536));
    endtask

    // A getup holds everything; the first free tick tracks again.
    task automatic test_getup_hold();
        send_item(request_item(REQ_GETUP_START));
        send_item(tick_item(1'b1, 16'd0, 24'sd1000, 24'sd500, 24'sd200));
        send_item(request_item(REQ_GETUP_END));
        send_item(tick_item(1'b1, 16'd0, 24'sd1000, 24'sd500, 24'sd200));
    endtask

    // Pitch near +-pi plus a full bias runs past 16 bits and clips.
    task automatic test_pitch_saturation();
        apply_setting(90, 45, ANGLE_MAX, 1);
        send_item(tick_item(1'b1, 16'd0, 24'sh800000, 24'sd7, 24'sd1));
        apply_setting(90, 45, -ANGLE_MAX, 1);
        send_item(tick_item(1'b1, 16'd0, 24'sh800000, -24'sd7, -24'sd1));
    endtask

    // Three slots with no dwell walk 0,1,2,0,1; shrinking the count below the
    // pointer forces a wrap before the next read.
    task automatic test_scan_wrap();
        apply_setting(90, 0, 0, 3);
        repeat (5) send_item(tick_item(1'b0, 16'd0, '0, '0, '0));
        apply_setting(90, 0, 0, 0);
        send_item(tick_item(1'b0, 16'd0, '0, '0, '0));
    endtask

    task automatic run_random_phase(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned n;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8:
                    send_item(tick_item(1'b1, pick_age(), pick_coord(), pick_coord(),
                                        pick_coord()));
                9, 10, 11:
                    send_item(lost_tick());
                12, 13: begin
                    // target lost for a run of ticks, at times long enough to pass the dwell
                    n = (cfg_dwell < 60) ? $urandom_range(1, cfg_dwell + 3)
                                         : $urandom_range(1, 8);
                    repeat (n) send_item(lost_tick());
                end
                14, 15: begin
                    // well formed getup: hold, a few ticks, release
                    send_item(request_item(REQ_GETUP_START));
                    repeat ($urandom_range(1, 4))
                        send_item(($urandom_range(0, 1) == 0) ? lost_tick() :
                                  tick_item(1'b1, pick_age(), pick_coord(),
                                            pick_coord(), pick_coord()));
                    send_item(request_item(REQ_GETUP_END));
                end
                16:
                    send_item(write_item(4'($urandom()), pick_angle(), pick_angle()));
                17:
                    // stray release, or a hold that the next getup will clear
                    send_item(request_item(($urandom_range(0, 3) == 0) ? REQ_GETUP_START
                                                                        : REQ_GETUP_END));
                default:
                    send_item(tick_item(1'($urandom_range(0, 1)), 16'($urandom()),
                                        pick_coord(), pick_coord(), pick_coord()));
            endcase
        end
        // leave no hold across a setting change
        send_item(request_item(REQ_GETUP_END));
    endtask

    task automatic test_random_traffic();
        // fill every slot so that any count may be used
        for (int s = 0; s < SLOT_COUNT; s++)
            send_item(write_item(s[3:0], pick_angle(), pick_angle()));
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_setting(90, 3, 0, 16);
                1: apply_setting(1, 0, ANGLE_MAX, 5);
                2: apply_setting(16'hFFFF, 16'hFFFF, -ANGLE_MAX, 31);   // never scans
                3: apply_setting(20, 10, $urandom_range(0, 2 * ANGLE_MAX) - ANGLE_MAX, 0);
                4: apply_setting(0, 2, -1000, 9);                       // never tracks
                5: apply_setting(200, 45, 12345, 16);
                default:
                    apply_setting($urandom_range(1, 200), $urandom_range(0, 20),
                                  $urandom_range(0, 2 * ANGLE_MAX) - ANGLE_MAX,
                                  $urandom_range(1, 20));
            endcase
            run_random_phase((RANDOM_ITEMS - SLOT_COUNT) / PHASES);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_scan();
        test_tracking_angles();
        test_getup_hold();
        test_pitch_saturation();
        test_scan_wrap();
        test_random_traffic();
        wait_idle();

        $display("Covered %0d items over %0d register settings", items_sent, settings_done);
        $display("Checked %0d tracked aims and %0d scan moves", tracked_seen, scans_seen);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[gaze_track_or_scan_sequencer.f]
rtl/core/gtss_pkg.sv
rtl/core/gtss_cordic.sv
rtl/core/gtss_scan_table.sv
rtl/core/gaze_track_or_scan_sequencer.sv
tb/gaze_track_or_scan_sequencer_test.sv
